// File: hdl/usdt_pkg.sv
// shared types, constants and codes of the udp socket demux table
package usdt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 4;
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BIND    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CONNECT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SEND    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_PORT_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_END   = 1'b1;

    localparam logic [PORT_W-1:0] PORT_START_RST = 16'd1024;
    localparam logic [PORT_W-1:0] PORT_END_RST   = 16'd65535;

    typedef enum logic [STAT_W-1:0] {
        ST_OK, ST_NOMATCH, ST_BOUND, ST_INUSE, ST_REMOTE, ST_FULL, ST_NOPORT
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  slot_index;
        logic [ADDR_W-1:0] local_addr;
        logic [PORT_W-1:0] local_port_in;
        logic [ADDR_W-1:0] peer_addr;
        logic [PORT_W-1:0] remote_port_in;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  slot_out;
        logic [PORT_W-1:0] port_out;
    } out_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lip;
        logic [PORT_W-1:0] lport;
        logic [ADDR_W-1:0] rip;
        logic [PORT_W-1:0] rport;
    } entry_t;

    typedef enum logic [1:0] {WR_OPEN, WR_CONNECT, WR_BIND, WR_PORT} wr_kind_t;

    typedef enum logic [1:0] {RES_PORT_NONE, RES_PORT_ENT, RES_PORT_LAST} res_port_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_FETCH, S_EVAL, S_SCAN_RD, S_SCAN_CHK, S_TRY, S_REM, S_DONE
    } ctl_state_t;

    typedef struct packed {
        logic      load_item;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      rd_en;
        logic      rd_cnt;
        logic      save_ent;
        logic      wr_en;
        wr_kind_t  wr_kind;
        logic      set_valid;
        logic      clr_valid;
        logic      tries_init;
        logic      tries_dec;
        logic      port_step;
        logic      rem_start;
        logic      port_from_rem;
        logic      res_en;
        status_t   res_status;
        logic      res_slot;
        res_port_t res_port;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic have;
        logic scan_hit;
        logic scan_last;
        logic ent_lport_nz;
        logic remote_mis;
        logic tries_zero;
        logic tries_last;
        logic x_in_range;
        logic rem_done;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/usdt_rem.sv
// bit-serial remainder unit for the ephemeral port wrap
module usdt_rem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [usdt_pkg::PORT_W:0]    dividend,
    input  logic [usdt_pkg::PORT_W-1:0]  divisor,
    output logic                         done,
    output logic [usdt_pkg::PORT_W-1:0]  rem
);
    localparam int DW = usdt_pkg::PORT_W + 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [4:0]    step_reg, step_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] sh_reg, sh_next;
    logic [DW-1:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        trial     = {rem_reg[DW-2:0], sh_reg[DW-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = 5'(DW - 1);
            rem_next  = '0;
            sh_next   = dividend;
        end else if (busy_reg) begin
            // one quotient bit per cycle, keep only the remainder
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
            end else begin
                rem_next = trial;
            end
            sh_next = {sh_reg[DW-2:0], 1'b0};
            if (step_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[DW-2:0];
endmodule

// File: hdl/usdt_dp.sv
// datapath: socket table memory, valid bits, config, port allocator and result
module usdt_dp #(
    parameter int SLOTS = usdt_pkg::SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [usdt_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [usdt_pkg::CFG_DAT_W-1:0]  cfg_wr_data,
    input  usdt_pkg::in_word_t              s_data,
    input  usdt_pkg::dp_cmd_t               cmd,
    output usdt_pkg::dp_stat_t              stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output usdt_pkg::out_word_t             m_data
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW = usdt_pkg::PORT_W;

    usdt_pkg::in_word_t  item_reg;
    usdt_pkg::entry_t    mem [SLOTS];
    usdt_pkg::entry_t    rdata_reg;
    usdt_pkg::entry_t    ent_reg;
    usdt_pkg::entry_t    wr_data;
    usdt_pkg::out_word_t pend_reg;
    usdt_pkg::out_word_t out_reg;
    logic                out_valid_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [IW-1:0]       cnt_reg;
    logic [IW-1:0]       idx_w;
    logic [IW-1:0]       rd_addr;
    logic [IW-1:0]       wr_addr;
    logic                idx_ok;
    logic                v_cur;
    logic [PW-1:0]       start_reg;
    logic [PW-1:0]       end_reg;
    logic [PW-1:0]       last_reg;
    logic [PW-1:0]       tries_reg;
    logic [PW:0]         x_val;
    logic                rem_done;
    logic [PW-1:0]       rem_val;
    logic [PW-1:0]       res_port_val;

    assign idx_w   = IW'(item_reg.slot_index);
    assign idx_ok  = 32'(item_reg.slot_index) < 32'(SLOTS);
    assign rd_addr = cmd.rd_cnt ? cnt_reg : idx_w;
    assign wr_addr = (cmd.wr_kind == usdt_pkg::WR_OPEN) ? cnt_reg : idx_w;
    assign v_cur   = valid_reg[cnt_reg];
    assign x_val   = {1'b0, last_reg} + 17'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= usdt_pkg::PORT_START_RST;
            end_reg   <= usdt_pkg::PORT_END_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                usdt_pkg::REG_PORT_START: start_reg <= cfg_wr_data;
                usdt_pkg::REG_PORT_END:   end_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
        if (cmd.save_ent)  ent_reg  <= rdata_reg;
        if (cmd.tries_init) begin
            tries_reg <= end_reg - start_reg;
        end else if (cmd.tries_dec) begin
            tries_reg <= tries_reg - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.set_valid) valid_reg[cnt_reg] <= 1'b1;
            if (cmd.clr_valid) valid_reg[idx_w]   <= 1'b0;
        end
    end

    always_comb begin
        unique case (cmd.wr_kind)
            usdt_pkg::WR_OPEN:    wr_data = '0;
            usdt_pkg::WR_CONNECT: wr_data = {rdata_reg.lip, rdata_reg.lport,
                                             item_reg.peer_addr, item_reg.remote_port_in};
            usdt_pkg::WR_BIND:    wr_data = {item_reg.local_addr, item_reg.local_port_in,
                                             ent_reg.rip, ent_reg.rport};
            usdt_pkg::WR_PORT:    wr_data = {ent_reg.lip, last_reg, ent_reg.rip, ent_reg.rport};
            default:              wr_data = '0;
        endcase
    end

    // single-port style table, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) mem[wr_addr] <= wr_data;
        if (cmd.rd_en) rdata_reg <= mem[rd_addr];
    end

    usdt_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.rem_start),
        .dividend (x_val),
        .divisor  (end_reg),
        .done     (rem_done),
        .rem      (rem_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= usdt_pkg::PORT_START_RST - 16'd1;
        end else if (cmd.port_step) begin
            last_reg <= (x_val < {1'b0, end_reg}) ? x_val[PW-1:0] : start_reg;
        end else if (cmd.port_from_rem) begin
            last_reg <= (rem_val == '0) ? start_reg : rem_val;
        end
    end

    always_comb begin
        stat.mode         = item_reg.mode;
        stat.have         = idx_ok ? valid_reg[idx_w] : 1'b0;
        stat.scan_last    = cnt_reg == IW'(SLOTS - 1);
        stat.ent_lport_nz = rdata_reg.lport != '0;
        stat.remote_mis   = (rdata_reg.rip != '0 && rdata_reg.rip != item_reg.peer_addr) ||
                            (rdata_reg.rport != '0 &&
                             rdata_reg.rport != item_reg.remote_port_in);
        stat.tries_zero   = !(end_reg > start_reg);
        stat.tries_last   = tries_reg == 16'd1;
        stat.x_in_range   = x_val <= {1'b0, end_reg};
        stat.rem_done     = rem_done;
        stat.out_free     = !out_valid_reg || m_ready;
        unique case (item_reg.mode)
            usdt_pkg::MODE_LOOKUP:
                stat.scan_hit = v_cur && rdata_reg.lport == item_reg.local_port_in &&
                    (rdata_reg.lip == '0 || rdata_reg.lip == item_reg.local_addr) &&
                    (rdata_reg.rip == '0 || rdata_reg.rip == item_reg.peer_addr) &&
                    (rdata_reg.rport == '0 || rdata_reg.rport == item_reg.remote_port_in);
            usdt_pkg::MODE_OPEN:
                stat.scan_hit = !v_cur;
            usdt_pkg::MODE_BIND:
                stat.scan_hit = v_cur && rdata_reg.lport == item_reg.local_port_in &&
                                rdata_reg.lip == item_reg.local_addr;
            usdt_pkg::MODE_SEND:
                stat.scan_hit = v_cur && rdata_reg.lport == last_reg;
            default:
                stat.scan_hit = 1'b0;
        endcase
    end

    always_comb begin
        unique case (cmd.res_port)
            usdt_pkg::RES_PORT_ENT:  res_port_val = rdata_reg.lport;
            usdt_pkg::RES_PORT_LAST: res_port_val = last_reg;
            default:                 res_port_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_en) begin
            pend_reg.status   <= cmd.res_status;
            pend_reg.slot_out <= cmd.res_slot ? 4'(cnt_reg) : '0;
            pend_reg.port_out <= res_port_val;
        end
        if (cmd.out_load) out_reg <= pend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

// File: hdl/usdt_ctl.sv
// controller: sequences each operation over the datapath
module usdt_ctl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  usdt_pkg::dp_stat_t  stat,
    output usdt_pkg::dp_cmd_t   cmd
);
    usdt_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= usdt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            usdt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = usdt_pkg::S_DECODE;
                end
            end
            usdt_pkg::S_DECODE: begin
                cmd.cnt_clr = 1'b1;
                state_next  = usdt_pkg::S_DONE;
                cmd.res_en  = 1'b1;
                cmd.res_status = usdt_pkg::ST_NOMATCH;
                if (stat.mode == usdt_pkg::MODE_LOOKUP || stat.mode == usdt_pkg::MODE_OPEN) begin
                    cmd.res_en = 1'b0;
                    state_next = usdt_pkg::S_SCAN_RD;
                end else if (stat.have && stat.mode == usdt_pkg::MODE_CLOSE) begin
                    cmd.clr_valid  = 1'b1;
                    cmd.res_status = usdt_pkg::ST_OK;
                end else if (stat.have && (stat.mode == usdt_pkg::MODE_BIND ||
                             stat.mode == usdt_pkg::MODE_CONNECT ||
                             stat.mode == usdt_pkg::MODE_SEND)) begin
                    cmd.res_en = 1'b0;
                    state_next = usdt_pkg::S_FETCH;
                end
            end
            usdt_pkg::S_FETCH: begin
                cmd.rd_en  = 1'b1;
                state_next = usdt_pkg::S_EVAL;
            end
            usdt_pkg::S_EVAL: begin
                cmd.save_ent = 1'b1;
                state_next   = usdt_pkg::S_DONE;
                cmd.res_en   = 1'b1;
                if (stat.mode == usdt_pkg::MODE_CONNECT) begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_kind    = usdt_pkg::WR_CONNECT;
                    cmd.res_status = usdt_pkg::ST_OK;
                end else if (stat.mode == usdt_pkg::MODE_BIND) begin
                    if (stat.ent_lport_nz) begin
                        cmd.res_status = usdt_pkg::ST_BOUND;
                    end else begin
                        cmd.res_en = 1'b0;
                        state_next = usdt_pkg::S_SCAN_RD;
                    end
                end else begin
                    if (stat.remote_mis) begin
                        cmd.res_status = usdt_pkg::ST_REMOTE;
                    end else if (stat.ent_lport_nz) begin
                        cmd.res_status = usdt_pkg::ST_OK;
                        cmd.res_port   = usdt_pkg::RES_PORT_ENT;
                    end else if (stat.tries_zero) begin
                        cmd.res_status = usdt_pkg::ST_NOPORT;
                    end else begin
                        cmd.res_en     = 1'b0;
                        cmd.tries_init = 1'b1;
                        state_next     = usdt_pkg::S_TRY;
                    end
                end
            end
            usdt_pkg::S_SCAN_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_cnt = 1'b1;
                state_next = usdt_pkg::S_SCAN_CHK;
            end
            usdt_pkg::S_SCAN_CHK: begin
                state_next = usdt_pkg::S_DONE;
                cmd.res_en = 1'b1;
                if (stat.scan_hit) begin
                    unique case (stat.mode)
                        usdt_pkg::MODE_LOOKUP: begin
                            cmd.res_status = usdt_pkg::ST_OK;
                            cmd.res_slot   = 1'b1;
                        end
                        usdt_pkg::MODE_OPEN: begin
                            cmd.wr_en      = 1'b1;
                            cmd.wr_kind    = usdt_pkg::WR_OPEN;
                            cmd.set_valid  = 1'b1;
                            cmd.res_status = usdt_pkg::ST_OK;
                            cmd.res_slot   = 1'b1;
                        end
                        usdt_pkg::MODE_BIND: begin
                            cmd.res_status = usdt_pkg::ST_INUSE;
                        end
                        default: begin
                            // port taken: next try or give up
                            if (stat.tries_last) begin
                                cmd.res_status = usdt_pkg::ST_NOPORT;
                            end else begin
                                cmd.res_en    = 1'b0;
                                cmd.tries_dec = 1'b1;
                                state_next    = usdt_pkg::S_TRY;
                            end
                        end
                    endcase
                end else if (stat.scan_last) begin
                    unique case (stat.mode)
                        usdt_pkg::MODE_LOOKUP: cmd.res_status = usdt_pkg::ST_NOMATCH;
                        usdt_pkg::MODE_OPEN:   cmd.res_status = usdt_pkg::ST_FULL;
                        usdt_pkg::MODE_BIND: begin
                            cmd.wr_en      = 1'b1;
                            cmd.wr_kind    = usdt_pkg::WR_BIND;
                            cmd.res_status = usdt_pkg::ST_OK;
                        end
                        default: begin
                            cmd.wr_en      = 1'b1;
                            cmd.wr_kind    = usdt_pkg::WR_PORT;
                            cmd.res_status = usdt_pkg::ST_OK;
                            cmd.res_port   = usdt_pkg::RES_PORT_LAST;
                        end
                    endcase
                end else begin
                    cmd.res_en  = 1'b0;
                    cmd.cnt_inc = 1'b1;
                    state_next  = usdt_pkg::S_SCAN_RD;
                end
            end
            usdt_pkg::S_TRY: begin
                cmd.cnt_clr = 1'b1;
                if (stat.x_in_range) begin
                    cmd.port_step = 1'b1;
                    state_next    = usdt_pkg::S_SCAN_RD;
                end else begin
                    cmd.rem_start = 1'b1;
                    state_next    = usdt_pkg::S_REM;
                end
            end
            usdt_pkg::S_REM: begin
                if (stat.rem_done) begin
                    cmd.port_from_rem = 1'b1;
                    state_next        = usdt_pkg::S_SCAN_RD;
                end
            end
            usdt_pkg::S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = usdt_pkg::S_IDLE;
                end
            end
            default: state_next = usdt_pkg::S_IDLE;
        endcase
    end
endmodule

// File: hdl/udp_socket_demux_table.sv
// top level of the udp socket demux table
//
// A table of SLOTS udp socket entries (local ip/port, remote ip/port, zero is
// a wildcard). Each input word is one operation: receive lookup, open, bind,
// connect, close or send_prepare; each gives exactly one result word. One
// operation is in flight at a time; the result sits in an output register so
// the next word is taken while the previous result waits. Run time is set by
// the table memory's single registered read port, scanned slot by slot:
// lookup and open scan the table (stopping early on a hit), bind scans it
// too; connect, close, mismatching sends and absent slots do not scan.
// A send_prepare that allocates a port runs up to port_end-port_start tries,
// each a scan of the table, plus one pass of the bit-serial remainder unit
// when the previous port lies at or above port_end and has to be wrapped.
// Config writes must only happen while the block is idle. No clearing pass
// after reset: the valid bits gate every read of the table.
module udp_socket_demux_table #(
    parameter int SLOTS = usdt_pkg::SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [usdt_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [usdt_pkg::CFG_DAT_W-1:0]  cfg_wr_data,
    // operation words in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  usdt_pkg::in_word_t              s_data,
    // result words out
    output logic                            m_valid,
    input  logic                            m_ready,
    output usdt_pkg::out_word_t             m_data
);
    usdt_pkg::dp_cmd_t  cmd;
    usdt_pkg::dp_stat_t stat;

    // sequencer
    usdt_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table, config registers, allocator and result register
    usdt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );
endmodule

// File: hdl/usdt_chk.sv
// port-level checker for the udp socket demux table, bound to the top level
module usdt_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input usdt_pkg::out_word_t m_data
);
    // a waiting result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one operation at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on back to back cycles");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // failed operations report no slot and no port
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != usdt_pkg::ST_OK |->
            m_data.slot_out == '0 && m_data.port_out == '0)
        else $error("failed result carries slot or port");

    // status code in range
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 3'd7)
        else $error("undefined status code");
endmodule

bind udp_socket_demux_table usdt_chk u_usdt_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/sv/tb_udp_socket_demux_table.sv
// testbench for the udp socket demux table: directed and random operations, scoreboard check
module tb_udp_socket_demux_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT       = usdt_pkg::SLOTS_DEF;
    localparam int PHASE_ITEMS = 140;
    localparam int CYCLE_LIMIT = 3000000;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_addr    = usdt_pkg::REG_PORT_START;
    logic [15:0]         cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    usdt_pkg::in_word_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    usdt_pkg::out_word_t m_data;

    // operation words waiting for the driver, results still owed by the block
    usdt_pkg::in_word_t  op_queue[$];
    usdt_pkg::out_word_t owed_results[$];

    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 0;
    int  rx_stall_pct  = 0;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;

    // shadow of the socket table and registers
    bit          tbl_valid [NSLOT];
    logic [31:0] tbl_lip   [NSLOT];
    logic [15:0] tbl_lport [NSLOT];
    logic [31:0] tbl_rip   [NSLOT];
    logic [15:0] tbl_rport [NSLOT];
    logic [15:0] last_port;
    logic [15:0] range_start;
    logic [15:0] range_end;

    udp_socket_demux_table u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** udp_socket_demux_table: FAILED **");
            $finish;
        end
    end

    function automatic bit port_taken(logic [15:0] p);
        for (int s = 0; s < NSLOT; s++)
            if (tbl_valid[s] && tbl_lport[s] == p) return 1'b1;
        return 1'b0;
    endfunction

    // next-state and result of the table for one operation word
    task automatic table_step(input usdt_pkg::in_word_t w, output usdt_pkg::out_word_t r);
        bit                have;
        bit                found;
        usdt_pkg::status_t st;
        logic [3:0]        so;
        logic [15:0]       po;
        int unsigned       tries;
        int unsigned       nxt;
        int                k;
        have = tbl_valid[w.slot_index];
        st = usdt_pkg::ST_NOMATCH;
        so = '0;
        po = '0;
        if (w.mode == usdt_pkg::MODE_LOOKUP) begin
            for (int s = 0; s < NSLOT; s++) begin
                if (tbl_valid[s] && tbl_lport[s] == w.local_port_in
                    && (tbl_lip[s] == 0 || tbl_lip[s] == w.local_addr)
                    && (tbl_rip[s] == 0 || tbl_rip[s] == w.peer_addr)
                    && (tbl_rport[s] == 0 || tbl_rport[s] == w.remote_port_in)) begin
                    st = usdt_pkg::ST_OK;
                    so = s[3:0];
                    break;
                end
            end
        end else if (w.mode == usdt_pkg::MODE_OPEN) begin
            st = usdt_pkg::ST_FULL;
            for (int s = 0; s < NSLOT; s++) begin
                if (!tbl_valid[s]) begin
                    tbl_valid[s] = 1'b1;
                    tbl_lip[s]   = '0;
                    tbl_lport[s] = '0;
                    tbl_rip[s]   = '0;
                    tbl_rport[s] = '0;
                    st = usdt_pkg::ST_OK;
                    so = s[3:0];
                    break;
                end
            end
        end else if (w.mode == usdt_pkg::MODE_BIND && have) begin
            if (tbl_lport[w.slot_index] != 0) begin
                st = usdt_pkg::ST_BOUND;
            end else begin
                st = usdt_pkg::ST_OK;
                for (int s = 0; s < NSLOT; s++)
                    if (tbl_valid[s] && tbl_lport[s] == w.local_port_in
                        && tbl_lip[s] == w.local_addr) st = usdt_pkg::ST_INUSE;
                if (st == usdt_pkg::ST_OK) begin
                    tbl_lip[w.slot_index]   = w.local_addr;
                    tbl_lport[w.slot_index] = w.local_port_in;
                end
            end
        end else if (w.mode == usdt_pkg::MODE_CONNECT && have) begin
            tbl_rip[w.slot_index]   = w.peer_addr;
            tbl_rport[w.slot_index] = w.remote_port_in;
            st = usdt_pkg::ST_OK;
        end else if (w.mode == usdt_pkg::MODE_CLOSE && have) begin
            tbl_valid[w.slot_index] = 1'b0;
            st = usdt_pkg::ST_OK;
        end else if (w.mode == usdt_pkg::MODE_SEND && have) begin
            k = w.slot_index;
            if ((tbl_rip[k] != 0 && tbl_rip[k] != w.peer_addr)
                || (tbl_rport[k] != 0 && tbl_rport[k] != w.remote_port_in)) begin
                st = usdt_pkg::ST_REMOTE;
            end else begin
                found = (tbl_lport[k] != 0);
                if (!found) begin
                    // wrapping ephemeral search
                    tries = (range_end > range_start) ? range_end - range_start : 0;
                    for (int unsigned i = 0; i < tries; i++) begin
                        nxt = (32'(last_port) + 1) % 32'(range_end);
                        if (nxt == 0) nxt = range_start;
                        last_port = nxt[15:0];
                        if (!port_taken(last_port)) begin
                            tbl_lport[k] = last_port;
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (found) begin
                    st = usdt_pkg::ST_OK;
                    po = tbl_lport[k];
                end else begin
                    st = usdt_pkg::ST_NOPORT;
                end
            end
        end
        r.status   = st;
        r.slot_out = so;
        r.port_out = po;
    endtask

    task automatic queue_op(input usdt_pkg::in_word_t w);
        usdt_pkg::out_word_t r;
        table_step(w, r);
        op_queue.push_back(w);
        owed_results.push_back(r);
    endtask

    task automatic queue_fields(input logic [2:0] md, input logic [3:0] idx,
                                input logic [31:0] la, input logic [15:0] lp,
                                input logic [31:0] ra, input logic [15:0] rp);
        usdt_pkg::in_word_t w;
        w.mode = md;
        w.slot_index = idx;
        w.local_addr = la;
        w.local_port_in = lp;
        w.peer_addr = ra;
        w.remote_port_in = rp;
        queue_op(w);
    endtask

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(4))
            0: return 32'h0;
            1: return 32'hC0A8_0001;
            2: return 32'h0A00_0002;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(5))
            0: return 16'h0;
            1: return 16'd53;
            2: return 16'd5000;
            3: return range_start + 16'($urandom_range(3));
            4: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly an open slot, so deep paths get exercised
    function automatic logic [3:0] pick_slot();
        int live[$];
        for (int s = 0; s < NSLOT; s++)
            if (tbl_valid[s]) live.push_back(s);
        if (live.size() > 0 && $urandom_range(9) < 8)
            return 4'(live[$urandom_range(live.size() - 1)]);
        return 4'($urandom);
    endfunction

    task automatic queue_random();
        usdt_pkg::in_word_t w;
        int                 roll;
        int                 s;
        roll = $urandom_range(99);
        w.slot_index = pick_slot();
        w.local_addr = pick_addr();
        w.local_port_in = pick_port();
        w.peer_addr = pick_addr();
        w.remote_port_in = pick_port();
        s = w.slot_index;
        if (roll < 30) begin
            w.mode = usdt_pkg::MODE_LOOKUP;
            // packet aimed at an existing socket, sometimes slightly off
            if (tbl_valid[s] && $urandom_range(9) < 7) begin
                w.local_port_in = tbl_lport[s];
                if (tbl_lip[s] != 0) w.local_addr = tbl_lip[s];
                if (tbl_rip[s] != 0) w.peer_addr = tbl_rip[s];
                if (tbl_rport[s] != 0) w.remote_port_in = tbl_rport[s];
                if ($urandom_range(5) == 0) w.peer_addr[$urandom_range(31)] ^= 1'b1;
            end
        end else if (roll < 44) begin
            w.mode = usdt_pkg::MODE_OPEN;
        end else if (roll < 58) begin
            w.mode = usdt_pkg::MODE_BIND;
        end else if (roll < 67) begin
            w.mode = usdt_pkg::MODE_CONNECT;
        end else if (roll < 78) begin
            w.mode = usdt_pkg::MODE_CLOSE;
        end else if (roll < 95) begin
            w.mode = usdt_pkg::MODE_SEND;
            if ($urandom_range(9) < 7) begin
                if (tbl_rip[s] != 0) w.peer_addr = tbl_rip[s];
                if (tbl_rport[s] != 0) w.remote_port_in = tbl_rport[s];
            end
        end else begin
            w.mode = 3'($urandom_range(6, 7));
        end
        queue_op(w);
    endtask

    task automatic cfg_write(input logic a, input logic [15:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= a;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (a == usdt_pkg::REG_PORT_START) range_start = v;
        else range_end = v;
    endtask

    task automatic drain();
        while (op_queue.size() > 0 || owed_results.size() > 0) @(posedge aclk);
        // allow the block to settle before touching registers
        repeat (50) @(posedge aclk);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    endtask

    // sender: one word per handshake, with random idle cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= op_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    <= 400;
            hold_request <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and scoreboard
    always @(posedge aclk) begin
        usdt_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                report("unexpected word", m_data, 0);
            end else begin
                want = owed_results.pop_front();
                if (m_data.status !== want.status) report("status", m_data.status, want.status);
                if (m_data.slot_out !== want.slot_out)
                    report("slot_out", m_data.slot_out, want.slot_out);
                if (m_data.port_out !== want.port_out)
                    report("port_out", m_data.port_out, want.port_out);
            end
        end
        m_ready <= aresetn && hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
    end

    initial begin
        logic [15:0] starts [6];
        logic [15:0] ends   [6];
        starts = '{16'd1024, 16'd1, 16'd40000, 16'd100, 16'd65535, 16'd1};
        ends   = '{16'd65535, 16'd65535, 16'd40004, 16'd100, 16'd2, 16'd2};
        for (int s = 0; s < NSLOT; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_lip[s] = '0;
            tbl_lport[s] = '0;
            tbl_rip[s] = '0;
            tbl_rport[s] = '0;
        end
        range_start = usdt_pkg::PORT_START_RST;
        range_end   = usdt_pkg::PORT_END_RST;
        last_port   = usdt_pkg::PORT_START_RST - 16'd1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: opens, bind conflicts, connect, lookups, sends, absent slots
        queue_fields(usdt_pkg::MODE_OPEN, 4'd0, '0, '0, '0, '0);
        queue_fields(usdt_pkg::MODE_OPEN, 4'd0, '0, '0, '0, '0);
        queue_fields(usdt_pkg::MODE_OPEN, 4'd0, '0, '0, '0, '0);
        queue_fields(usdt_pkg::MODE_BIND, 4'd0, 32'hC0A8_0001, 16'd5000, '0, '0);
        queue_fields(usdt_pkg::MODE_BIND, 4'd0, 32'hC0A8_0001, 16'd6000, '0, '0);
        queue_fields(usdt_pkg::MODE_BIND, 4'd1, 32'hC0A8_0001, 16'd5000, '0, '0);
        queue_fields(usdt_pkg::MODE_BIND, 4'd1, 32'h0, 16'hFFFF, '0, '0);
        queue_fields(usdt_pkg::MODE_CONNECT, 4'd0, '0, '0, 32'h0A00_0002, 16'd53);
        queue_fields(usdt_pkg::MODE_LOOKUP, 4'd0, 32'hC0A8_0001, 16'd5000,
                     32'h0A00_0002, 16'd53);
        queue_fields(usdt_pkg::MODE_LOOKUP, 4'd0, 32'hC0A8_0001, 16'd5000,
                     32'h0A00_0003, 16'd53);
        queue_fields(usdt_pkg::MODE_LOOKUP, 4'd0, 32'hFFFF_FFFF, 16'hFFFF,
                     32'hFFFF_FFFF, 16'hFFFF);
        queue_fields(usdt_pkg::MODE_SEND, 4'd0, '0, '0, 32'h0A00_0002, 16'd54);
        queue_fields(usdt_pkg::MODE_SEND, 4'd0, '0, '0, 32'h0A00_0002, 16'd53);
        queue_fields(usdt_pkg::MODE_SEND, 4'd2, '0, '0, 32'hFFFF_FFFF, 16'hFFFF);
        queue_fields(usdt_pkg::MODE_SEND, 4'd2, '0, '0, 32'h1, 16'h1);
        queue_fields(usdt_pkg::MODE_CLOSE, 4'd1, '0, '0, '0, '0);
        queue_fields(usdt_pkg::MODE_BIND, 4'd1, 32'h1, 16'd7, '0, '0);
        queue_fields(usdt_pkg::MODE_CONNECT, 4'd15, '0, '0, 32'h1, 16'd1);
        queue_fields(usdt_pkg::MODE_SEND, 4'd9, '0, '0, '0, '0);
        queue_fields(3'd6, 4'd0, '0, '0, '0, '0);
        queue_fields(3'd7, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        // sender pauses until everything has come back
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                cfg_write(usdt_pkg::REG_PORT_START, starts[p]);
                cfg_write(usdt_pkg::REG_PORT_END, ends[p]);
            end
            send_idle_pct = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 34 : 0;
            rx_stall_pct  = (p % 4 == 2) ? 54 : (p % 4 == 3) ? 34 : 0;
            // receiver stops for a long while as this phase starts
            if (p == 1) hold_request <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) queue_random();
            drain();
        end

        if (mismatches == 0) begin
            $display("** udp_socket_demux_table: PASSED **");
        end else begin
            $display("** udp_socket_demux_table: FAILED **");
        end
        $finish;
    end

endmodule
